/* rtl/lav_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Types, widths and row codes shared by the look-at view matrix block.
// ----------------------------------------------------------------------------
package lav_pkg;

    // Fixed-point format of every input and output word.
    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;

    // Vectors are rescaled so that their largest magnitude is in
    // [2^(PS_BITS-1), 2^PS_BITS) before a length is taken.
    localparam int PS_BITS      = 30;
    localparam int COARSE_SHIFT = 8;

    // Widest magnitude the rescaler sees: a direction difference or a
    // cross product of a unit axis with a rescaled up vector.
    localparam int MAG_BITS  = (WORD_BITS + 1 > FRACTION_BITS + 32) ?
                               WORD_BITS + 1 : FRACTION_BITS + 32;
    localparam int SQ_BITS   = 2 * PS_BITS + 2;
    localparam int ROOT_BITS = PS_BITS + 1;
    localparam int NUM_BITS  = PS_BITS + FRACTION_BITS + 1;
    localparam int QUO_BITS  = FRACTION_BITS + 1;

    // Signed width of u, v and w components, and of the second multiplier
    // operand (position word or rescaled up component).
    localparam int AXIS_BITS = FRACTION_BITS + 4;
    localparam int MB_BITS   = (WORD_BITS > PS_BITS + 1) ? WORD_BITS : PS_BITS + 1;
    localparam int PROD_BITS = AXIS_BITS + MB_BITS;

    localparam int LAV_QUEUE_DEPTH = 4;

    // Row codes on the result channel.
    localparam logic [1:0] ROW_U = 2'd0;
    localparam logic [1:0] ROW_V = 2'd1;
    localparam logic [1:0] ROW_W = 2'd2;
    localparam logic [1:0] ROW_T = 2'd3;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [WORD_BITS:0]   t_dir;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] position_x;
        logic signed [WORD_BITS-1:0] position_y;
        logic signed [WORD_BITS-1:0] position_z;
        logic signed [WORD_BITS-1:0] aim_x;
        logic signed [WORD_BITS-1:0] aim_y;
        logic signed [WORD_BITS-1:0] aim_z;
        logic signed [WORD_BITS-1:0] up_x;
        logic signed [WORD_BITS-1:0] up_y;
        logic signed [WORD_BITS-1:0] up_z;
        logic                        aim_is_target;
    } t_lav_in;

    typedef struct packed {
        logic [1:0]                  row_index;
        logic signed [WORD_BITS-1:0] row_x;
        logic signed [WORD_BITS-1:0] row_y;
        logic signed [WORD_BITS-1:0] row_z;
        logic                        degenerate;
        logic                        last_row;
    } t_lav_out;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        t_word [2:0] pos;
        t_dir  [2:0] dir;
        t_word [2:0] up;
        logic        dir_zero;
    } t_lav_entry;

endpackage

/* rtl/lav_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_front
// Input stage: takes one item, forms the view direction and flags a zero
// direction, then hands the classified item to the work queue.
// ----------------------------------------------------------------------------
module lav_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lav_pkg::t_lav_in    i_item,
    output logic                o_full,
    output logic                o_valid,
    output lav_pkg::t_lav_entry o_entry,
    input  logic                i_q_full
);
    import lav_pkg::*;

    logic       r_valid;
    t_lav_entry r_entry;
    t_lav_entry entry_c;
    t_word      pos_c [3];
    t_word      aim_c [3];
    logic       accept;

    // The stage holds while the queue is full.
    assign o_full  = r_valid && i_q_full;
    assign accept  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    // Direction is the aim itself or the aim minus the position.
    always_comb begin
        pos_c[0] = i_item.position_x;
        pos_c[1] = i_item.position_y;
        pos_c[2] = i_item.position_z;
        aim_c[0] = i_item.aim_x;
        aim_c[1] = i_item.aim_y;
        aim_c[2] = i_item.aim_z;
        entry_c.up[0] = i_item.up_x;
        entry_c.up[1] = i_item.up_y;
        entry_c.up[2] = i_item.up_z;
        for (int i = 0; i < 3; i++) begin
            entry_c.pos[i] = pos_c[i];
            if (i_item.aim_is_target) begin
                entry_c.dir[i] = (WORD_BITS+1)'(aim_c[i]) - (WORD_BITS+1)'(pos_c[i]);
            end else begin
                entry_c.dir[i] = (WORD_BITS+1)'(aim_c[i]);
            end
        end
        entry_c.dir_zero = (entry_c.dir[0] == '0) && (entry_c.dir[1] == '0) &&
                           (entry_c.dir[2] == '0);
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (r_valid && !i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= entry_c;
        end
    end

endmodule

/* rtl/lav_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lav_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lav_pkg::SQ_BITS-1:0]   i_radicand,
    output logic                          o_done,
    output logic [lav_pkg::ROOT_BITS-1:0] o_root
);
    import lav_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [SQ_BITS-1:0] r_n;
    logic [SQ_BITS-1:0] r_r;
    logic [SQ_BITS-1:0] r_bit;
    logic [SQ_BITS:0]   trial;

    assign trial  = (SQ_BITS+1)'(r_r) + (SQ_BITS+1)'(r_bit);
    assign o_done = r_done;
    assign o_root = r_r[ROOT_BITS-1:0];

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // One trial subtraction per cycle, the test bit moving down by two.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_radicand;
            r_r   <= '0;
            r_bit <= SQ_BITS'(1) << (SQ_BITS - 2);
        end else if (r_busy) begin
            if ((SQ_BITS+1)'(r_n) >= trial) begin
                r_n <= r_n - trial[SQ_BITS-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

/* rtl/lav_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_div
// Restoring divider, one quotient bit per cycle, for quotients known to
// fit in QUO_BITS.
// ----------------------------------------------------------------------------
module lav_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lav_pkg::NUM_BITS-1:0]  i_num,
    input  logic [lav_pkg::ROOT_BITS-1:0] i_den,
    output logic                          o_done,
    output logic [lav_pkg::QUO_BITS-1:0]  o_quo
);
    import lav_pkg::*;

    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [ROOT_BITS-1:0] r_den;
    logic [ROOT_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0]  r_quo;
    logic [ROOT_BITS:0]   trial;
    logic                 ge;

    assign trial  = {r_rem, r_quo[QUO_BITS-1]};
    assign ge     = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(QUO_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The low numerator bits shift out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= ROOT_BITS'(i_num[NUM_BITS-1:QUO_BITS]);
            r_quo <= i_num[QUO_BITS-1:0];
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= ROOT_BITS'(trial - {1'b0, r_den});
            end else begin
                r_rem <= ROOT_BITS'(trial);
            end
            r_quo <= {r_quo[QUO_BITS-2:0], ge};
        end
    end

endmodule

/* rtl/lav_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_back
// Back end: a sequencer over a rescaler, squarers, a square-root unit, three
// divider lanes and six multipliers builds u, v, w and the translation, and
// a four-row output bank serves them to the result channel.
// ----------------------------------------------------------------------------
module lav_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  lav_pkg::t_lav_entry i_q_entry,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output lav_pkg::t_lav_out   o_result
);
    import lav_pkg::*;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_PS        = 4'd1;
    localparam logic [3:0] ST_SQ        = 4'd2;
    localparam logic [3:0] ST_SQRT      = 4'd3;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd4;
    localparam logic [3:0] ST_DIV       = 4'd5;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd6;
    localparam logic [3:0] ST_CROSS     = 4'd7;
    localparam logic [3:0] ST_CDIFF     = 4'd8;
    localparam logic [3:0] ST_TMUL      = 4'd9;
    localparam logic [3:0] ST_TSUM      = 4'd10;
    localparam logic [3:0] ST_DONE      = 4'd11;

    // Which vector the rescale and normalize path is working on.
    localparam logic [1:0] PH_W  = 2'd0;
    localparam logic [1:0] PH_UP = 2'd1;
    localparam logic [1:0] PH_U  = 2'd2;
    localparam logic [1:0] PH_V  = 2'd3;

    localparam logic signed [PROD_BITS+1:0] HALF = (PROD_BITS+2)'(1) << (FRACTION_BITS - 1);

    logic [3:0] r_state;
    logic [1:0] r_phase;
    logic [1:0] r_k;
    logic       r_degen;

    logic [MAG_BITS-1:0]         r_m   [3];
    logic                        r_neg [3];
    logic [2*PS_BITS-1:0]        r_sq  [3];
    logic [ROOT_BITS-1:0]        r_len;
    logic signed [AXIS_BITS-1:0] r_w   [3];
    logic signed [AXIS_BITS-1:0] r_u   [3];
    logic signed [AXIS_BITS-1:0] r_v   [3];
    logic signed [WORD_BITS-1:0] r_t   [3];
    logic signed [WORD_BITS-1:0] r_pos [3];
    logic signed [WORD_BITS-1:0] r_up  [3];
    logic signed [PROD_BITS-1:0] r_prod [6];

    // Output bank.
    logic signed [WORD_BITS-1:0] r_ob [4][3];
    logic                        r_ob_degen;
    logic                        r_ob_full;
    logic [1:0]                  r_ob_idx;

    logic [MAG_BITS-1:0]         mx;
    logic                        ps_r8, ps_r1, ps_l8, ps_l1;
    logic signed [AXIS_BITS-1:0] mult_a [6];
    logic signed [MB_BITS-1:0]   mult_b [6];
    logic signed [AXIS_BITS-1:0] axis_k [3];
    logic signed [MB_BITS-1:0]   b_vec  [3];
    logic signed [PROD_BITS:0]   cdiff  [3];
    logic [PROD_BITS:0]          cmag   [3];
    logic signed [PROD_BITS:0]   cround [3];
    logic                        czero;
    logic [WORD_BITS:0]          upmag  [3];
    logic [WORD_BITS:0]          dirmag [3];
    logic                        up_zero;
    logic signed [PROD_BITS+1:0] tsum;
    logic signed [PROD_BITS+1:0] tneg;
    logic signed [WORD_BITS-1:0] tsat;

    logic                  sqrt_start, sqrt_done;
    logic [SQ_BITS-1:0]    radicand;
    logic [ROOT_BITS-1:0]  root;
    logic                  div_start;
    logic [2:0]            div_done;
    logic [NUM_BITS-1:0]   div_num [3];
    logic [QUO_BITS-1:0]   div_quo [3];
    logic signed [AXIS_BITS-1:0] quo_s [3];

    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign sqrt_start = (r_state == ST_SQRT);
    assign div_start  = (r_state == ST_DIV);
    assign radicand   = SQ_BITS'(r_sq[0]) + SQ_BITS'(r_sq[1]) + SQ_BITS'(r_sq[2]);

    // Rescale decision: coarse and fine shifts toward [2^29, 2^30).
    assign mx    = r_m[0] | r_m[1] | r_m[2];
    assign ps_r8 = |mx[MAG_BITS-1:PS_BITS+COARSE_SHIFT];
    assign ps_r1 = |mx[MAG_BITS-1:PS_BITS];
    assign ps_l8 = ~|mx[MAG_BITS-1:PS_BITS-1-COARSE_SHIFT];
    assign ps_l1 = ~mx[PS_BITS-1];

    // Square root and divider lanes.
    lav_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        assign div_num[g] = NUM_BITS'({r_m[g][PS_BITS-1:0], {FRACTION_BITS{1'b0}}}) +
                            NUM_BITS'(r_len >> 1);
        lav_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (div_num[g]),
            .i_den   (r_len),
            .o_done  (div_done[g]),
            .o_quo   (div_quo[g])
        );
    end

    // Operand selection, magnitudes, cross differences and rounding.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quo_s[i] = AXIS_BITS'({1'b0, div_quo[i]});
            if (r_neg[i]) begin
                quo_s[i] = -quo_s[i];
            end
            upmag[i]  = r_up[i][WORD_BITS-1] ? -(WORD_BITS+1)'(r_up[i])
                                             : (WORD_BITS+1)'(r_up[i]);
            dirmag[i] = i_q_entry.dir[i][WORD_BITS] ? -i_q_entry.dir[i]
                                                    : i_q_entry.dir[i];
            if (r_phase == PH_UP) begin
                b_vec[i] = MB_BITS'({1'b0, r_m[i][PS_BITS-1:0]});
                if (r_neg[i]) begin
                    b_vec[i] = -b_vec[i];
                end
            end else begin
                b_vec[i] = MB_BITS'(r_u[i]);
            end
            cdiff[i]  = (PROD_BITS+1)'(r_prod[2*i]) - (PROD_BITS+1)'(r_prod[2*i+1]);
            cmag[i]   = cdiff[i][PROD_BITS] ? -cdiff[i] : cdiff[i];
            cround[i] = (cdiff[i] + (PROD_BITS+1)'(HALF)) >>> FRACTION_BITS;
        end
        up_zero = (r_up[0] == '0) && (r_up[1] == '0) && (r_up[2] == '0);
        czero   = (cdiff[0] == '0) && (cdiff[1] == '0) && (cdiff[2] == '0);

        unique case (r_k)
            2'd0:    axis_k = r_u;
            2'd1:    axis_k = r_v;
            default: axis_k = r_w;
        endcase

        for (int p = 0; p < 6; p++) begin
            mult_a[p] = '0;
            mult_b[p] = '0;
        end
        if (r_state == ST_CROSS) begin
            mult_a[0] = r_w[1]; mult_b[0] = b_vec[2];
            mult_a[1] = r_w[2]; mult_b[1] = b_vec[1];
            mult_a[2] = r_w[2]; mult_b[2] = b_vec[0];
            mult_a[3] = r_w[0]; mult_b[3] = b_vec[2];
            mult_a[4] = r_w[0]; mult_b[4] = b_vec[1];
            mult_a[5] = r_w[1]; mult_b[5] = b_vec[0];
        end else begin
            for (int i = 0; i < 3; i++) begin
                mult_a[i] = axis_k[i];
                mult_b[i] = MB_BITS'(r_pos[i]);
            end
        end
    end

    // Translation: dot product rounded half up, then negated and saturated.
    always_comb begin
        tsum = (PROD_BITS+2)'(r_prod[0]) + (PROD_BITS+2)'(r_prod[1]) +
               (PROD_BITS+2)'(r_prod[2]);
        tneg = -((tsum + HALF) >>> FRACTION_BITS);
        if ((&tneg[PROD_BITS+1:WORD_BITS-1]) || (~|tneg[PROD_BITS+1:WORD_BITS-1])) begin
            tsat = tneg[WORD_BITS-1:0];
        end else begin
            tsat = {tneg[PROD_BITS+1], {(WORD_BITS-1){~tneg[PROD_BITS+1]}}};
        end
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_W;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_phase <= PH_W;
                        r_state <= i_q_entry.dir_zero ? ST_DONE : ST_PS;
                    end
                end
                ST_PS: begin
                    if (!ps_r1 && !ps_l1) begin
                        r_state <= (r_phase == PH_UP) ? ST_CROSS : ST_SQ;
                    end
                end
                ST_SQ:   r_state <= ST_SQRT;
                ST_SQRT: r_state <= ST_SQRT_WAIT;
                ST_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV:  r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (&div_done) begin
                        if (r_phase == PH_W) begin
                            r_phase <= PH_UP;
                            r_state <= up_zero ? ST_DONE : ST_PS;
                        end else begin
                            r_phase <= PH_V;
                            r_state <= ST_CROSS;
                        end
                    end
                end
                ST_CROSS: r_state <= ST_CDIFF;
                ST_CDIFF: begin
                    if (r_phase == PH_UP) begin
                        r_phase <= PH_U;
                        r_state <= czero ? ST_DONE : ST_PS;
                    end else begin
                        r_k     <= '0;
                        r_state <= ST_TMUL;
                    end
                end
                ST_TMUL: r_state <= ST_TSUM;
                ST_TSUM: begin
                    if (r_k == 2'd2) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_TMUL;
                    end
                end
                ST_DONE: begin
                    if (!r_ob_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_degen <= i_q_entry.dir_zero;
                for (int i = 0; i < 3; i++) begin
                    r_pos[i] <= i_q_entry.pos[i];
                    r_up[i]  <= i_q_entry.up[i];
                    r_m[i]   <= MAG_BITS'(dirmag[i]);
                    r_neg[i] <= i_q_entry.dir[i][WORD_BITS];
                end
            end
            ST_PS: begin
                for (int i = 0; i < 3; i++) begin
                    priority if (ps_r8) begin
                        r_m[i] <= r_m[i] >> COARSE_SHIFT;
                    end else if (ps_r1) begin
                        r_m[i] <= r_m[i] >> 1;
                    end else if (ps_l8) begin
                        r_m[i] <= r_m[i] << COARSE_SHIFT;
                    end else if (ps_l1) begin
                        r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_m[i] <= r_m[i];
                    end
                end
            end
            ST_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i] <= r_m[i][PS_BITS-1:0] * r_m[i][PS_BITS-1:0];
                end
            end
            ST_SQRT_WAIT: begin
                r_len <= root;
            end
            ST_DIV_WAIT: begin
                if (&div_done) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_phase == PH_W) begin
                            r_w[i]   <= quo_s[i];
                            r_m[i]   <= MAG_BITS'(upmag[i]);
                            r_neg[i] <= r_up[i][WORD_BITS-1];
                        end else begin
                            r_u[i] <= quo_s[i];
                        end
                    end
                    if (r_phase == PH_W) begin
                        r_degen <= up_zero;
                    end
                end
            end
            ST_CROSS, ST_TMUL: begin
                for (int p = 0; p < 6; p++) begin
                    r_prod[p] <= PROD_BITS'(mult_a[p]) * PROD_BITS'(mult_b[p]);
                end
            end
            ST_CDIFF: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_phase == PH_UP) begin
                        r_m[i]   <= MAG_BITS'(cmag[i]);
                        r_neg[i] <= cdiff[i][PROD_BITS];
                    end else begin
                        r_v[i] <= AXIS_BITS'(cround[i]);
                    end
                end
                if (r_phase == PH_UP) begin
                    r_degen <= czero;
                end
            end
            ST_TSUM: begin
                r_t[r_k] <= tsat;
            end
            default: begin
            end
        endcase
    end

    // Output bank: one finished item, served a row per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_full <= 1'b0;
            r_ob_idx  <= ROW_U;
        end else if (r_state == ST_DONE && !r_ob_full) begin
            r_ob_full <= 1'b1;
            r_ob_idx  <= ROW_U;
        end else if (i_pop && r_ob_full) begin
            if (r_ob_idx == ROW_T) begin
                r_ob_full <= 1'b0;
                r_ob_idx  <= ROW_U;
            end else begin
                r_ob_idx <= r_ob_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && !r_ob_full) begin
            r_ob_degen <= r_degen;
            for (int i = 0; i < 3; i++) begin
                r_ob[ROW_U][i] <= r_degen ? '0 : WORD_BITS'(r_u[i]);
                r_ob[ROW_V][i] <= r_degen ? '0 : WORD_BITS'(r_v[i]);
                r_ob[ROW_W][i] <= r_degen ? '0 : WORD_BITS'(r_w[i]);
                r_ob[ROW_T][i] <= r_degen ? '0 : r_t[i];
            end
        end
    end

    assign o_empty             = !r_ob_full;
    assign o_result.row_index  = r_ob_idx;
    assign o_result.row_x      = r_ob[r_ob_idx][0];
    assign o_result.row_y      = r_ob[r_ob_idx][1];
    assign o_result.row_z      = r_ob[r_ob_idx][2];
    assign o_result.degenerate = r_ob_degen;
    assign o_result.last_row   = (r_ob_idx == ROW_T);

endmodule

/* rtl/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix: u, v, w and translation rows of a camera view matrix.
// A zero direction gives a degenerate item with zero rows.
// Items go one at a time through two roots and two divides; the queue holds later ones.
// Reset: synchronous, active low; control state clears, queue and output bank empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module look_at_view_matrix #(
    parameter int QUEUE_DEPTH = lav_pkg::LAV_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  lav_pkg::t_lav_in  i_item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output lav_pkg::t_lav_out o_result
);
    import lav_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic                front_valid;
    t_lav_entry          front_entry;
    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    t_lav_entry          r_q [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    // Front end.
    lav_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_valid  (front_valid),
        .o_entry  (front_entry),
        .i_q_full (q_full)
    );

    // Work queue between the front and back ends.
    assign q_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (r_count != '0);
    assign q_push  = front_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (q_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (q_push && !q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (q_pop && !q_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wr_ptr] <= front_entry;
        end
    end

    // Back end.
    lav_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (r_q[r_rd_ptr]),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    // The back end never takes from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (r_count != '0))
        else $error("work queue popped while empty");

    // A row transfer other than the last leaves the rest of the item waiting.
    a_rows_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last_row) |=> !empty)
        else $error("result rows lost before the translation row");

    // Rows follow each other in order within an item.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last_row) |=>
        (o_result.row_index == $past(o_result.row_index) + 2'd1))
        else $error("result rows out of order");

    // A degenerate item carries zero rows.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.degenerate) |->
        (o_result.row_x == '0 && o_result.row_y == '0 && o_result.row_z == '0))
        else $error("degenerate row is not zero");
`endif

endmodule
